@@ rtl/cbor_hd_pkg.sv @@
// ----------------------------------------------------------------------------
// CBOR item head decoder package
// Shared types, codes and the half-to-single float widening function.
// ----------------------------------------------------------------------------
package cbor_hd_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_HEAD    = 2'd0,
    PH_ARG     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Major types
  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NEGINT = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  // Additional info codes
  localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
  localparam logic [4:0] AI_HALF      = 5'd25;
  localparam logic [4:0] AI_SINGLE    = 5'd26;
  localparam logic [4:0] AI_DOUBLE    = 5'd27;
  localparam logic [4:0] AI_RESERVED  = 5'd28;

  // Float kinds
  localparam logic [1:0] FK_NONE   = 2'd0;
  localparam logic [1:0] FK_SINGLE = 2'd1;
  localparam logic [1:0] FK_DOUBLE = 2'd2;

  // Result status
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_BUFFER_LENGTH = 1'b0;

  // Float constants
  localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
  localparam logic [31:0] SINGLE_EXP_MAX = 32'h7F80_0000;
  localparam logic [7:0]  EXP_REBIAS     = 8'd112;
  localparam logic [7:0]  SUBN_EXP_BASE  = 8'd103;
  localparam logic [3:0]  HALF_MAN_BITS  = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  major_type;
    logic [4:0]  additional_info;
    logic [63:0] argument;
    logic [63:0] signed_value;
    logic [15:0] payload_offset;
    logic [1:0]  float_kind;
    logic [31:0] single_bits;
  } result_t;

  // Widen IEEE half to single bits; subnormal halves are normalized.
  function automatic logic [31:0] half_to_single(input logic [15:0] half);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lead;
    logic [3:0]  shift;
    logic [9:0]  norm;
    logic [7:0]  exp_s;
    logic [31:0] res;
    sgn  = {half[15], 31'b0};
    ex   = half[14:10];
    man  = half[9:0];
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) begin
        lead = 4'(i);
      end
    end
    shift = HALF_MAN_BITS - lead;
    norm  = man << shift;
    exp_s = SUBN_EXP_BASE + {4'b0, lead};
    if (ex == '0) begin
      if (man == '0) begin
        res = sgn;
      end else begin
        res = sgn | {1'b0, exp_s, norm, 13'b0};
      end
    end else if (ex == HALF_EXP_MAX) begin
      res = sgn | SINGLE_EXP_MAX | {9'b0, man, 13'b0};
    end else begin
      res = {half[15], {3'b0, ex} + EXP_REBIAS, man, 13'b0};
    end
    return res;
  endfunction

endpackage

@@ rtl/cbor_hd_in_reg.sv @@
// ----------------------------------------------------------------------------
// CBOR head decoder input register
// Holds one accepted byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module cbor_hd_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cbor_hd_pkg::in_item_t in_item_i,
  input  logic                  consume_i,
  output logic                  item_valid_o,
  output cbor_hd_pkg::in_item_t item_o
);

  logic                  valid_q, valid_d;
  cbor_hd_pkg::in_item_t item_q;

  // Take a new byte when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/cbor_hd_core.sv @@
// ----------------------------------------------------------------------------
// CBOR head decoder core
// Cursor, phase and argument state; decodes one byte per advance.
// ----------------------------------------------------------------------------
module cbor_hd_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  cbor_hd_pkg::in_item_t item_i,
  input  logic [15:0]           buffer_length_i,
  output logic                  produce_o,
  output cbor_hd_pkg::result_t  result_o
);

  localparam int unsigned CMP_W = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;

  logic [OFFSET_BITS-1:0] off_q, off_d, eff_off, off_inc;
  cbor_hd_pkg::phase_e    phase_q, phase_d, eff_phase;
  logic [7:0]             held_q, held_d, eff_held;
  logic [63:0]            acc_q, acc_d, eff_acc;
  logic [3:0]             abl_q, abl_d, eff_abl;
  logic [15:0]            pbl_q, pbl_d, eff_pbl;
  logic                   err_q, err_d, eff_err;

  logic [CMP_W-1:0] off_x, inc_x, len_x, need_x;
  logic [15:0]      rem;
  logic             active;
  logic [4:0]       ai;
  logic [3:0]       nbytes;
  logic             fin;
  logic [7:0]       fin_head;
  logic [63:0]      fin_arg;
  logic [2:0]       fin_major;
  logic [4:0]       fin_ai;
  logic             give_err;
  cbor_hd_pkg::result_t res;

  // Restart clears the state before the byte is looked at
  always_comb begin
    if (item_i.restart) begin
      eff_off   = '0;
      eff_phase = cbor_hd_pkg::PH_HEAD;
      eff_held  = '0;
      eff_acc   = '0;
      eff_abl   = '0;
      eff_pbl   = '0;
      eff_err   = 1'b0;
    end else begin
      eff_off   = off_q;
      eff_phase = phase_q;
      eff_held  = held_q;
      eff_acc   = acc_q;
      eff_abl   = abl_q;
      eff_pbl   = pbl_q;
      eff_err   = err_q;
    end
  end

  assign off_inc = eff_off + 1'b1;
  assign off_x   = CMP_W'(eff_off);
  assign inc_x   = CMP_W'(off_inc);
  assign len_x   = CMP_W'(buffer_length_i);
  assign active  = !eff_err && (off_x < len_x);
  assign rem     = (len_x > inc_x) ? 16'(len_x - inc_x) : 16'd0;
  assign ai      = item_i.data_byte[4:0];
  assign nbytes  = 4'd1 << ai[1:0];
  assign need_x  = inc_x + CMP_W'(nbytes);

  assign fin_major = fin_head[7:5];
  assign fin_ai    = fin_head[4:0];

  always_comb begin
    off_d    = eff_off;
    phase_d  = eff_phase;
    held_d   = eff_held;
    acc_d    = eff_acc;
    abl_d    = eff_abl;
    pbl_d    = eff_pbl;
    err_d    = eff_err;
    fin      = 1'b0;
    fin_head = eff_held;
    fin_arg  = eff_acc;
    give_err = 1'b0;
    res      = '0;

    if (active) begin
      off_d = off_inc;
      case (eff_phase)
        cbor_hd_pkg::PH_PAYLOAD: begin
          pbl_d = eff_pbl - {15'b0, (eff_pbl != '0)};
          if (pbl_d == '0) begin
            phase_d = cbor_hd_pkg::PH_HEAD;
          end
        end
        cbor_hd_pkg::PH_ARG: begin
          acc_d = {eff_acc[55:0], item_i.data_byte};
          abl_d = eff_abl - {3'b0, (eff_abl != '0)};
          if (abl_d == '0) begin
            phase_d  = cbor_hd_pkg::PH_HEAD;
            fin      = 1'b1;
            fin_head = eff_held;
            fin_arg  = acc_d;
          end
        end
        default: begin
          phase_d = cbor_hd_pkg::PH_HEAD;
          held_d  = item_i.data_byte;
          if (ai >= cbor_hd_pkg::AI_RESERVED) begin
            give_err = 1'b1;
          end else if (ai < cbor_hd_pkg::AI_ONE_BYTE) begin
            acc_d    = {59'b0, ai};
            fin      = 1'b1;
            fin_head = item_i.data_byte;
            fin_arg  = {59'b0, ai};
          end else if (need_x > len_x) begin
            give_err = 1'b1;
          end else begin
            acc_d   = '0;
            abl_d   = nbytes;
            phase_d = cbor_hd_pkg::PH_ARG;
          end
        end
      endcase

      if (fin) begin
        res.status          = cbor_hd_pkg::ST_OK;
        res.major_type      = fin_major;
        res.additional_info = fin_ai;
        res.argument        = fin_arg;
        case (fin_major)
          cbor_hd_pkg::MT_UINT: begin
            res.signed_value = fin_arg;
          end
          cbor_hd_pkg::MT_NEGINT: begin
            res.signed_value = fin_arg[63] ? {1'b1, 63'b0} : ~fin_arg;
          end
          cbor_hd_pkg::MT_BYTES, cbor_hd_pkg::MT_TEXT: begin
            if (fin_arg > {48'b0, rem}) begin
              give_err = 1'b1;
            end else begin
              res.payload_offset = 16'(off_inc);
              pbl_d              = fin_arg[15:0];
              if (fin_arg != '0) begin
                phase_d = cbor_hd_pkg::PH_PAYLOAD;
              end
            end
          end
          cbor_hd_pkg::MT_ARRAY: begin
            give_err = fin_arg > {48'b0, rem};
          end
          cbor_hd_pkg::MT_MAP: begin
            give_err = fin_arg > {49'b0, rem[15:1]};
          end
          cbor_hd_pkg::MT_SIMPLE: begin
            if (fin_ai == cbor_hd_pkg::AI_HALF) begin
              res.float_kind  = cbor_hd_pkg::FK_SINGLE;
              res.single_bits = cbor_hd_pkg::half_to_single(fin_arg[15:0]);
            end else if (fin_ai == cbor_hd_pkg::AI_SINGLE) begin
              res.float_kind  = cbor_hd_pkg::FK_SINGLE;
              res.single_bits = fin_arg[31:0];
            end else if (fin_ai == cbor_hd_pkg::AI_DOUBLE) begin
              res.float_kind  = cbor_hd_pkg::FK_DOUBLE;
            end
          end
          default: begin
          end
        endcase
      end

      // Error result carries only the status; stay silent until restart
      if (give_err) begin
        err_d      = 1'b1;
        phase_d    = cbor_hd_pkg::PH_HEAD;
        res        = '0;
        res.status = cbor_hd_pkg::ST_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      phase_q <= cbor_hd_pkg::PH_HEAD;
      held_q  <= '0;
      acc_q   <= '0;
      abl_q   <= '0;
      pbl_q   <= '0;
      err_q   <= 1'b0;
    end else if (advance_i) begin
      off_q   <= off_d;
      phase_q <= phase_d;
      held_q  <= held_d;
      acc_q   <= acc_d;
      abl_q   <= abl_d;
      pbl_q   <= pbl_d;
      err_q   <= err_d;
    end
  end

  assign produce_o = fin || give_err;
  assign result_o  = res;

endmodule

@@ rtl/cbor_hd_out_reg.sv @@
// ----------------------------------------------------------------------------
// CBOR head decoder result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module cbor_hd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 produce_i,
  input  cbor_hd_pkg::result_t result_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output cbor_hd_pkg::result_t result_o
);

  logic                 valid_q, valid_d;
  cbor_hd_pkg::result_t result_q;

  always_comb begin
    if (advance_i) begin
      valid_d = produce_i;
    end else begin
      valid_d = valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && produce_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ rtl/cbor_item_head_decoder_top.sv @@
// ----------------------------------------------------------------------------
// CBOR item head decoder, top level
// Path: an accepted byte is held in the input register, and its result is registered
// in the result register. Throughput: one byte per cycle while the result register is not
// stalled; the decode stage updates cursor and argument state from the input register.
// Reset: asynchronous, clears cursor, phase, error flag, handshake state and
// buffer_length; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cbor_item_head_decoder_top #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Byte input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                restart_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                status_o,
  output logic [2:0]                          major_type_o,
  output logic [4:0]                          additional_info_o,
  output logic [63:0]                         argument_o,
  output logic signed [63:0]                  signed_value_o,
  output logic [15:0]                         payload_offset_o,
  output logic [1:0]                          float_kind_o,
  output logic [31:0]                         single_bits_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbor_hd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cbor_hd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cbor_hd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                pready
);

  logic [15:0]           blen_q;
  logic                  cfg_wr;
  logic                  item_valid;
  logic                  advance;
  logic                  produce;
  cbor_hd_pkg::in_item_t in_item, item;
  cbor_hd_pkg::result_t  res, res_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == cbor_hd_pkg::REG_BUFFER_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= '0;
    end else if (cfg_wr) begin
      blen_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == cbor_hd_pkg::REG_BUFFER_LENGTH) ?
                  {16'b0, blen_q} : '0;

  assign in_item.data_byte = data_byte_i;
  assign in_item.restart   = restart_i;

  // Decode when a byte is held and the result register is free or draining
  assign advance = item_valid && (!out_valid_o || out_ready_i);

  cbor_hd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .consume_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cbor_hd_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .item_i          (item),
    .buffer_length_i (blen_q),
    .produce_o       (produce),
    .result_o        (res)
  );

  cbor_hd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .produce_i   (produce),
    .result_i    (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (res_q)
  );

  assign status_o          = res_q.status;
  assign major_type_o      = res_q.major_type;
  assign additional_info_o = res_q.additional_info;
  assign argument_o        = res_q.argument;
  assign signed_value_o    = $signed(res_q.signed_value);
  assign payload_offset_o  = res_q.payload_offset;
  assign float_kind_o      = res_q.float_kind;
  assign single_bits_o     = res_q.single_bits;

  // Input side stalls only behind a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a pending result");

  // An error result carries nothing but its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cbor_hd_pkg::ST_ERROR) |->
      (argument_o == '0 && major_type_o == '0 && additional_info_o == '0 &&
       float_kind_o == cbor_hd_pkg::FK_NONE && single_bits_o == '0))
    else $error("error result with nonzero fields");

  // Float kinds only come from simple values with float info codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && float_kind_o != cbor_hd_pkg::FK_NONE) |->
      (major_type_o == cbor_hd_pkg::MT_SIMPLE &&
       (additional_info_o == cbor_hd_pkg::AI_HALF ||
        additional_info_o == cbor_hd_pkg::AI_SINGLE ||
        additional_info_o == cbor_hd_pkg::AI_DOUBLE)))
    else $error("float kind on a non-float item");

  // A nonzero payload offset does not exceed the buffer length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_offset_o != '0) |-> (payload_offset_o <= blen_q))
    else $error("payload offset beyond buffer length");

endmodule

@@ test/cbor_item_head_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// CBOR item head decoder testbench
// Streams CBOR buffers into the decoder, one byte per item, with bursty input
// and a stalling receiver. A byte-level decode model predicts each result, and
// the monitor checks every field in order. The buffer length is rewritten over
// the APB port between phases, from 0 up to 65535.
// ----------------------------------------------------------------------------
module cbor_item_head_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int unsigned ADDR_W = cbor_hd_pkg::APB_ADDR_W;
  localparam int unsigned DATA_W = cbor_hd_pkg::APB_DATA_W;

  // extremes, one item of each major type, half specials, then sticky errors
  localparam logic [7:0] DIRECTED_BUF [23] = '{
    8'h00, 8'h3B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h42, 8'hAA, 8'hBB, 8'h60, 8'h82, 8'hA1, 8'hC1,
    8'hF9, 8'h7C, 8'h00, 8'hF9, 8'h03, 8'hFF
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  status_o;
  logic [2:0]            major_type_o;
  logic [4:0]            additional_info_o;
  logic [63:0]           argument_o;
  logic signed [63:0]    signed_value_o;
  logic [15:0]           payload_offset_o;
  logic [1:0]            float_kind_o;
  logic [31:0]           single_bits_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  cbor_item_head_decoder_top #(
    .OFFSET_BITS(16)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .major_type_o      (major_type_o),
    .additional_info_o (additional_info_o),
    .argument_o        (argument_o),
    .signed_value_o    (signed_value_o),
    .payload_offset_o  (payload_offset_o),
    .float_kind_o      (float_kind_o),
    .single_bits_o     (single_bits_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Decode model state
  // --------------------------------------------------------------------------
  logic [15:0]          cur_len;
  logic [15:0]          cursor;
  cbor_hd_pkg::phase_e  dec_phase;
  logic [7:0]           head_byte;
  logic [63:0]          arg_acc;
  logic [3:0]           arg_left;
  logic [15:0]          pay_left;
  logic                 dec_error;

  cbor_hd_pkg::in_item_t pending_bytes [$];
  cbor_hd_pkg::result_t  expected_heads [$];

  bit          in_taken;
  int          mismatches;
  int          results_checked;
  int          error_results;
  int          bytes_sent;
  int          seg_cnt;
  bit          start_flag;
  int          burst_left;
  int          gap_left;
  logic [7:0]  ready_pat;
  logic [7:0]  ready_cnt;
  int          quiet_cycles;

  function automatic void clear_tracker();
    cursor    = '0;
    dec_phase = cbor_hd_pkg::PH_HEAD;
    head_byte = '0;
    arg_acc   = '0;
    arg_left  = '0;
    pay_left  = '0;
    dec_error = 1'b0;
  endfunction

  function automatic void flag_error(output cbor_hd_pkg::result_t r);
    dec_error = 1'b1;
    dec_phase = cbor_hd_pkg::PH_HEAD;
    r         = '0;
    r.status  = cbor_hd_pkg::ST_ERROR;
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] man;
    int          e;
    sgn = {h[15], 31'b0};
    ex  = h[14:10];
    man = {1'b0, h[9:0]};
    if (ex == 5'd0) begin
      if (man == '0) begin
        return sgn;
      end
      e = 1;
      // normalize the subnormal mantissa
      while (!man[10]) begin
        man = man << 1;
        e--;
      end
      return sgn | (32'(e + 112) << 23) | (32'(man[9:0]) << 13);
    end
    if (ex == 5'h1F) begin
      return sgn | 32'h7F80_0000 | (32'(man[9:0]) << 13);
    end
    return sgn | ((32'(ex) + 32'd112) << 23) | (32'(man[9:0]) << 13);
  endfunction

  function automatic bit item_done(output cbor_hd_pkg::result_t r);
    logic [2:0]  mt;
    logic [4:0]  ai;
    logic [63:0] arg;
    logic [31:0] rem;
    mt  = head_byte[7:5];
    ai  = head_byte[4:0];
    arg = arg_acc;
    rem = (cur_len > cursor) ? {16'b0, cur_len - cursor} : 32'd0;
    r   = '0;
    r.status          = cbor_hd_pkg::ST_OK;
    r.major_type      = mt;
    r.additional_info = ai;
    r.argument        = arg;
    case (mt)
      cbor_hd_pkg::MT_UINT: begin
        r.signed_value = arg;
      end
      cbor_hd_pkg::MT_NEGINT: begin
        r.signed_value = arg[63] ? 64'h8000_0000_0000_0000 : ~arg;
      end
      cbor_hd_pkg::MT_BYTES, cbor_hd_pkg::MT_TEXT: begin
        if (arg > {32'b0, rem}) begin
          flag_error(r);
          return 1'b1;
        end
        r.payload_offset = cursor;
        pay_left = arg[15:0];
        if (arg != 64'd0) begin
          dec_phase = cbor_hd_pkg::PH_PAYLOAD;
        end
      end
      cbor_hd_pkg::MT_ARRAY: begin
        if (arg > {32'b0, rem}) begin
          flag_error(r);
          return 1'b1;
        end
      end
      cbor_hd_pkg::MT_MAP: begin
        if (arg > {32'b0, rem >> 1}) begin
          flag_error(r);
          return 1'b1;
        end
      end
      cbor_hd_pkg::MT_SIMPLE: begin
        if (ai == cbor_hd_pkg::AI_HALF) begin
          r.float_kind  = cbor_hd_pkg::FK_SINGLE;
          r.single_bits = widen_half(arg[15:0]);
        end else if (ai == cbor_hd_pkg::AI_SINGLE) begin
          r.float_kind  = cbor_hd_pkg::FK_SINGLE;
          r.single_bits = arg[31:0];
        end else if (ai == cbor_hd_pkg::AI_DOUBLE) begin
          r.float_kind = cbor_hd_pkg::FK_DOUBLE;
        end
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Advance the model by one accepted byte; returns 1 when a result is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic rs,
                                     output cbor_hd_pkg::result_t r);
    logic [4:0]  ai;
    int unsigned n;
    r = '0;
    if (rs) begin
      clear_tracker();
    end
    if (dec_error || cursor >= cur_len) begin
      return 1'b0;
    end
    cursor = cursor + 16'd1;
    if (dec_phase == cbor_hd_pkg::PH_PAYLOAD) begin
      if (pay_left > 0) begin
        pay_left--;
      end
      if (pay_left == 0) begin
        dec_phase = cbor_hd_pkg::PH_HEAD;
      end
      return 1'b0;
    end
    if (dec_phase == cbor_hd_pkg::PH_ARG) begin
      arg_acc = {arg_acc[55:0], b};
      if (arg_left > 0) begin
        arg_left--;
      end
      if (arg_left != 0) begin
        return 1'b0;
      end
      dec_phase = cbor_hd_pkg::PH_HEAD;
      return item_done(r);
    end
    dec_phase = cbor_hd_pkg::PH_HEAD;
    head_byte = b;
    ai = b[4:0];
    if (ai >= cbor_hd_pkg::AI_RESERVED) begin
      flag_error(r);
      return 1'b1;
    end
    if (ai < cbor_hd_pkg::AI_ONE_BYTE) begin
      arg_acc = {59'b0, ai};
      return item_done(r);
    end
    n = 1 << (ai - cbor_hd_pkg::AI_ONE_BYTE);
    // head would run past the buffer end
    if ({16'b0, cursor} + n > {16'b0, cur_len}) begin
      flag_error(r);
      return 1'b1;
    end
    arg_acc   = '0;
    arg_left  = 4'(n);
    dec_phase = cbor_hd_pkg::PH_ARG;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    cbor_hd_pkg::in_item_t it;
    it.data_byte = b;
    it.restart   = start_flag;
    pending_bytes.push_back(it);
    start_flag = 1'b0;
    seg_cnt++;
    bytes_sent++;
  endtask

  function automatic logic [63:0] pick_upto(input logic [63:0] lim);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return lim;
      2: return (lim < 64'd16) ? r % (lim + 64'd1) : r % 64'd16;
      default: return (lim == '1) ? r : r % (lim + 64'd1);
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 8))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h0001;
      3: return 16'h83FF;
      4: return 16'h7C00;
      5: return 16'hFC00;
      6: return 16'h7E01;
      7: return 16'h7BFF;
      default: return 16'h0400;
    endcase
  endfunction

  // One item head plus its arguments and payload; left is room in the buffer.
  task automatic add_item(input int left);
    int          k;
    int          nb;
    int          hs;
    int          keep;
    logic [2:0]  mt;
    logic [4:0]  ai;
    logic [63:0] maxv;
    logic [63:0] cap;
    logic [63:0] v;
    bit          is_len;
    bit          bad;
    mt = 3'($urandom_range(0, 7));
    k  = $urandom_range(0, 4);
    nb = (k == 0) ? 0 : (1 << (k - 1));
    hs = 1 + nb;
    if (k == 0) begin
      maxv = 64'd23;
    end else if (k == 4) begin
      maxv = '1;
    end else begin
      maxv = (64'd1 << (8 * nb)) - 64'd1;
    end
    is_len = (mt == cbor_hd_pkg::MT_BYTES || mt == cbor_hd_pkg::MT_TEXT ||
              mt == cbor_hd_pkg::MT_ARRAY || mt == cbor_hd_pkg::MT_MAP);
    if (is_len) begin
      cap = (left > hs) ? 64'(left - hs) : 64'd0;
      if (mt == cbor_hd_pkg::MT_MAP) begin
        cap = cap / 2;
      end
      // overshoot now and then: string too long, count too large
      if ($urandom_range(0, 9) == 0) begin
        cap = cap + 64'($urandom_range(1, 3));
      end
      if (cap > maxv) begin
        cap = maxv;
      end
      v = pick_upto(cap);
    end else if (mt == cbor_hd_pkg::MT_SIMPLE && k == 2 && $urandom_range(0, 2) == 0) begin
      v = {48'b0, pick_half()};
    end else begin
      v = pick_upto(maxv);
    end
    ai  = (k == 0) ? v[4:0] : 5'(int'(cbor_hd_pkg::AI_ONE_BYTE) + k - 1);
    bad = ($urandom_range(0, 29) == 0);
    if (bad) begin
      ai = 5'($urandom_range(int'(cbor_hd_pkg::AI_RESERVED), 31));
      nb = 0;
    end
    push_byte({mt, ai});
    for (int i = nb - 1; i >= 0; i--) begin
      push_byte(v[8*i +: 8]);
    end
    if (!bad && (mt == cbor_hd_pkg::MT_BYTES || mt == cbor_hd_pkg::MT_TEXT)) begin
      keep = (left > hs) ? left - hs : 0;
      if (v < 64'(keep)) begin
        keep = int'(v);
      end
      repeat (keep) push_byte(8'($urandom));
    end
  endtask

  task automatic fill_buffer(input int total);
    start_flag = 1'b1;
    seg_cnt    = 0;
    while (seg_cnt < total) begin
      add_item(total - seg_cnt);
    end
    // trailing bytes past the buffer end
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
  endtask

  task automatic push_noise(input int cnt);
    repeat (cnt) begin
      start_flag = ($urandom_range(0, 15) == 0);
      push_byte(8'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_heads.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    // let the pipeline finish bytes that give no result
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [15:0] len);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(cbor_hd_pkg::REG_BUFFER_LENGTH));
    pwdata  <= {16'($urandom), len};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_len = len;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] len, input int quota);
    int seg;
    int phase_start;
    bit paused;
    wait_idle();
    write_len(len);
    // carry the old cursor across the length change
    start_flag = 1'b0;
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    phase_start = bytes_sent;
    paused      = 1'b0;
    while (bytes_sent - phase_start < quota) begin
      if (!paused && bytes_sent - phase_start >= quota / 2) begin
        // hold the sender until every pending result is out
        wait_idle();
        paused = 1'b1;
      end
      if (len == 16'd0 || $urandom_range(0, 7) == 0) begin
        push_noise($urandom_range(1, 8));
      end else begin
        if (len <= 16'd64) begin
          seg = int'(len);
        end else if (len <= 16'd300 && $urandom_range(0, 5) == 0) begin
          seg = int'(len);
        end else begin
          seg = $urandom_range(4, 48);
        end
        fill_buffer(seg);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of bytes with random gaps
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    cbor_hd_pkg::in_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the current item
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'($urandom);
    end else if (pending_bytes.size() > 0) begin
      it = pending_bytes.pop_front();
      data_byte_i <= it.data_byte;
      restart_i   <= it.restart;
      in_valid_i  <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 50);
        gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(0, 3);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: stall on an 8-bit ready pattern, reloaded when the low six counter bits reach zero
  always @(negedge clk_i) begin
    ready_cnt = ready_cnt + 8'd1;
    if (ready_cnt[5:0] == 6'd0) begin
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    end
    out_ready_i <= ready_pat[ready_cnt[2:0]];
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted bytes, check accepted results
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    cbor_hd_pkg::result_t r;
    bit                   due;
    in_taken = 1'b0;
    if (rst_ni) begin
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        due = decode_byte(data_byte_i, restart_i, r);
        if (due) begin
          expected_heads.push_back(r);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_heads.size() == 0) begin
          $display("%0t: unexpected result: status %0d major %0d argument %h",
                   $time, status_o, major_type_o, argument_o);
          mismatches++;
        end else begin
          r = expected_heads.pop_front();
          results_checked++;
          if (r.status == cbor_hd_pkg::ST_ERROR) begin
            error_results++;
          end
          check_field("status", 64'(r.status), 64'(status_o));
          check_field("major_type", 64'(r.major_type), 64'(major_type_o));
          check_field("additional_info", 64'(r.additional_info), 64'(additional_info_o));
          check_field("argument", r.argument, argument_o);
          check_field("signed_value", r.signed_value, signed_value_o);
          check_field("payload_offset", 64'(r.payload_offset), 64'(payload_offset_o));
          check_field("float_kind", 64'(r.float_kind), 64'(float_kind_o));
          check_field("single_bits", 64'(r.single_bits), 64'(single_bits_o));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cbor_item_head_decoder_top_tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    restart_i       = 1'b0;
    out_ready_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_taken        = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    error_results   = 0;
    bytes_sent      = 0;
    seg_cnt         = 0;
    start_flag      = 1'b0;
    burst_left      = 0;
    gap_left        = 0;
    ready_pat       = 8'hFF;
    ready_cnt       = '0;
    cur_len         = '0;
    clear_tracker();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    write_len(16'd40);
    start_flag = 1'b1;
    foreach (DIRECTED_BUF[i]) begin
      push_byte(DIRECTED_BUF[i]);
    end
    start_flag = 1'b1;
    push_byte(8'hFF);  // additional info 31, rejected as reserved
    push_byte(8'h05);  // dropped while the error is sticky
    start_flag = 1'b1;
    push_byte(8'h1C);  // reserved additional info

    run_phase(16'd1, 60);
    run_phase(16'd0, 20);
    run_phase(16'd3, 70);
    run_phase(16'd37, 110);
    run_phase(16'd200, 100);
    run_phase(16'hFFFF, 90);
    run_phase(16'd16, 90);
    run_phase(16'($urandom_range(2, 64)), 90);
    wait_idle();

    $display("Sent %0d bytes over buffer lengths 0 to 65535; checked %0d results (%0d errors).",
             bytes_sent, results_checked, error_results);
    if (mismatches == 0) begin
      $display("cbor_item_head_decoder_top_tb passed");
    end else begin
      $display("cbor_item_head_decoder_top_tb failed");
    end
    $finish;
  end

endmodule
